### rtl/core/shell_sort_knuth_gaps_unit_macros.svh
// Assertion macros shared by the sort core.
`ifndef SHELL_SORT_KNUTH_GAPS_UNIT_MACROS_SVH
`define SHELL_SORT_KNUTH_GAPS_UNIT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

### rtl/core/ssk_pkg.sv
`timescale 1ns / 1ps

package ssk_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int KEY_BITS   = 16;
   localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);
   localparam int DRAIN_BITS = $clog2(MAX_ITEMS);

   localparam logic [COUNT_BITS-1:0] COUNT_LAST = COUNT_BITS'(MAX_ITEMS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
   localparam logic [DRAIN_BITS-1:0] DRAIN_LAST = DRAIN_BITS'(MAX_ITEMS - 1);

   typedef struct packed {
      logic [KEY_BITS-1:0] key_in;
      logic                final_in;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key_out;
      logic                final_out;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
   } slot_type;

   typedef enum logic [1:0] {
      PHASE_LOAD,
      PHASE_DRAIN,
      PHASE_EMIT
   } phase_type;

endpackage

### rtl/core/ssk_cell.sv
`timescale 1ns / 1ps

module ssk_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  ssk_pkg::slot_type pass_left,
   input  ssk_pkg::slot_type held_right,
   output ssk_pkg::slot_type pass_right,
   output ssk_pkg::slot_type held
);
   import ssk_pkg::*;

   slot_type held_ff;
   slot_type held_in;
   slot_type pass_ff;
   slot_type pass_in;

   // keep the smaller key, hand the larger one on; on shift, take the key held by the right neighbour
   always_comb begin
      held_in = held_ff;
      pass_in = '0;
      if (shift) begin
         held_in = held_right;
      end else if (pass_left.valid) begin
         if (held_ff.valid) begin
            if (pass_left.key < held_ff.key) begin
               held_in.key = pass_left.key;
               pass_in     = '{valid: 1'b1, key: held_ff.key};
            end else begin
               pass_in = pass_left;
            end
         end else begin
            held_in = pass_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pass_ff <= '0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign pass_right = pass_ff;
   assign held       = held_ff;

endmodule

### rtl/core/shell_sort_knuth_gaps_unit.sv
// Sorting unit for sets of up to 64 unsigned 16-bit keys. Keys are loaded one word per cycle;
// a word marked final, or the 64th word, closes the set. Each key ripples into a row of 64
// compare-and-swap cells, one cell per cycle, so after the last key the unit settles for the
// travel time along the cell row and then streams the set out in ascending order, one word
// per cycle while the output is taken, marking the largest key as final. The next set is
// accepted as soon as the last word of the previous one sits in the output register.
`timescale 1ns / 1ps

module shell_sort_knuth_gaps_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssk_pkg::rsp_type rsp_data
);
   import ssk_pkg::*;

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic [DRAIN_BITS-1:0]  drain_ff;
   logic [DRAIN_BITS-1:0]  drain_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;
   rsp_type                rsp_data_in;

   logic     accept;
   logic     closing;
   logic     emit;
   logic     drain_run;
   slot_type pass [MAX_ITEMS+1];
   slot_type held [MAX_ITEMS+1];

   assign accept  = req_valid && req_ready;
   assign closing = accept && (req_data.final_in || (count_ff == COUNT_LAST));

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PHASE_LOAD: begin
            if (closing) phase_in = PHASE_DRAIN;
         end
         PHASE_DRAIN: begin
            if (drain_ff == DRAIN_LAST) phase_in = PHASE_EMIT;
         end
         PHASE_EMIT: begin
            if (emit && (count_ff == COUNT_ONE)) phase_in = PHASE_LOAD;
         end
         default: phase_in = PHASE_LOAD;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      drain_run = 1'b0;
      emit      = 1'b0;
      case (phase_ff)
         PHASE_LOAD:  req_ready = 1'b1;
         PHASE_DRAIN: drain_run = 1'b1;
         PHASE_EMIT:  emit      = !rsp_valid_ff || rsp_ready;
         default:     req_ready = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = count_ff + COUNT_ONE;
      end else if (emit) begin
         count_in = count_ff - COUNT_ONE;
      end
      drain_in = drain_run ? drain_ff + DRAIN_BITS'(1) : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.key_out   = held[0].key;
         rsp_data_in.final_out = (count_ff == COUNT_ONE);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_LOAD;
         count_ff     <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign pass[0]         = '{valid: accept, key: req_data.key_in};
   assign held[MAX_ITEMS] = '0;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      ssk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (emit),
         .pass_left  (pass[i]),
         .held_right (held[i+1]),
         .pass_right (pass[i+1]),
         .held       (held[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "shell_sort_knuth_gaps_unit_macros.svh"

   `ASSERT_NEVER(a_no_overflow, clock, reset, pass[MAX_ITEMS].valid)
   `ASSERT_IMPLIES(a_emit_has_key, clock, reset, phase_ff == PHASE_EMIT, held[0].valid)
   `ASSERT_IMPLIES(a_head_tracks_count, clock, reset, 1'b1, held[0].valid == (count_ff != '0))
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= COUNT_BITS'(MAX_ITEMS))

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import ssk_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 3 * MAX_ITEMS + 32;
   localparam int PHASE_ITEMS   = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type             sorted_q[$];
   logic [KEY_BITS-1:0] set_keys[MAX_ITEMS];
   int                  set_fill = 0;
   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;
   logic                hold_rsp = 1'b0;
   int                  fail_count = 0;
   int                  cycle_count = 0;
   event                start_hold;

   shell_sort_knuth_gaps_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Knuth-gap Shell sort of the gathered set, then queue it in ascending order
   task automatic sort_set_and_queue();
      int                  span;
      int                  scan;
      logic [KEY_BITS-1:0] moving;
      rsp_type             word;
      span = 1;
      while (span < set_fill) span = 3 * span + 1;
      while (span > 0) begin
         for (int pos = span; pos < set_fill; pos++) begin
            moving = set_keys[pos];
            scan = pos;
            while (scan >= span && moving <= set_keys[scan - span]) begin
               set_keys[scan] = set_keys[scan - span];
               scan -= span;
            end
            set_keys[scan] = moving;
         end
         span = span / 3;
      end
      for (int k = 0; k < set_fill; k++) begin
         word.key_out   = set_keys[k];
         word.final_out = (k == set_fill - 1);
         sorted_q.push_back(word);
      end
      set_fill = 0;
   endtask

   task automatic gather_key(input req_type w);
      set_keys[set_fill] = w.key_in;
      set_fill++;
      if (w.final_in || set_fill == MAX_ITEMS) sort_set_and_queue();
   endtask

   task automatic send_word(input logic [KEY_BITS-1:0] key, input logic last);
      req_type w;
      w.key_in   = key;
      w.final_in = last;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      gather_key(w);
   endtask

   task automatic send_keys(input logic [KEY_BITS-1:0] keys[$]);
      foreach (keys[i]) send_word(keys[i], i == keys.size() - 1);
   endtask

   task automatic send_set(input int count, input bit mark_last, input bit few_values);
      logic [KEY_BITS-1:0] key;
      for (int i = 0; i < count; i++) begin
         if (few_values) key = KEY_BITS'($urandom_range(3) * 32'h5555);
         else key = KEY_BITS'($urandom);
         send_word(key, mark_last && i == count - 1);
      end
   endtask

   task automatic wait_all_sorted();
      req_valid <= 1'b0;
      do @(posedge clock); while (sorted_q.size() != 0);
   endtask

   task automatic test_single_keys();
      send_word(16'h0000, 1'b1);
      send_word(16'hFFFF, 1'b1);
      send_word(16'hA5A5, 1'b1);
   endtask

   task automatic test_extreme_keys();
      logic [KEY_BITS-1:0] keys[$] = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
                                       16'h0001, 16'hFFFE};
      send_keys(keys);
   endtask

   task automatic test_equal_keys();
      logic [KEY_BITS-1:0] keys[$] = '{16'h1234, 16'h0007, 16'h1234, 16'h1234, 16'h0007};
      send_keys(keys);
   endtask

   task automatic test_reversed_keys();
      logic [KEY_BITS-1:0] keys[$] = '{16'h0050, 16'h0040, 16'h0030, 16'h0020, 16'h0010};
      send_keys(keys);
   endtask

   // a full store closes the set without a final word
   task automatic test_store_full();
      send_set(MAX_ITEMS, 1'b0, 1'b0);
      send_word(16'h4321, 1'b1);
      wait_all_sorted();
   endtask

   task automatic test_output_backpressure();
      -> start_hold;
      send_set(MAX_ITEMS, 1'b1, 1'b0);
      send_set(12, 1'b1, 1'b1);
      wait_all_sorted();
   endtask

   task automatic test_random_sets(input int send_pct, input int stall_pct);
      int items;
      int size;
      send_idle_pct = send_pct;
      rsp_stall_pct <= stall_pct;
      items = 0;
      while (items < PHASE_ITEMS) begin
         if ($urandom_range(9) == 0) size = $urandom_range(MAX_ITEMS, 13);
         else size = $urandom_range(12, 1);
         send_set(size, size < MAX_ITEMS ? 1'b1 : 1'($urandom_range(1)),
                  $urandom_range(3) == 0);
         items += size;
      end
      wait_all_sorted();
   endtask

   // hold the receiver off for a long stretch
   initial begin
      forever begin
         @(start_hold);
         hold_rsp <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_q.size() == 0) begin
            $error("rsp word with nothing outstanding: key_out %h final_out %b",
                   rsp_data.key_out, rsp_data.final_out);
            fail_count++;
         end else begin
            want = sorted_q.pop_front();
            if (rsp_data.key_out !== want.key_out) begin
               $error("key_out: expected %h, got %h", want.key_out, rsp_data.key_out);
               fail_count++;
            end
            if (rsp_data.final_out !== want.final_out) begin
               $error("final_out: expected %b, got %b", want.final_out, rsp_data.final_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("shell_sort_knuth_gaps_unit: mismatch");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_keys();
      test_extreme_keys();
      test_equal_keys();
      test_reversed_keys();
      wait_all_sorted();
      test_store_full();
      test_output_backpressure();
      test_random_sets(0, 0);
      test_random_sets(45, 0);
      test_random_sets(0, 45);
      test_random_sets(9, 9);
      wait_all_sorted();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("shell_sort_knuth_gaps_unit: match");
      end else begin
         $display("shell_sort_knuth_gaps_unit: mismatch");
      end
      $finish;
   end

endmodule
